>>> sv/dpf_pkg.sv
// Package for the shortest-path engine: sizes, command codes, sequencer states.
// No dependencies.
package dpf_pkg;
  localparam int NodeCount = 8;
  localparam int EdgeCount = 32;
  localparam int NodeW = 3;
  localparam int EdgeIdxW = 5;
  localparam int EdgeCntW = 6;
  localparam int WeightW = 16;
  localparam int DistW = 25;
  localparam int LimitW = 24;
  localparam logic [LimitW-1:0] LimitReset = 24'd37267;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SELECT,
    ST_RELAX,
    ST_TRACE,
    ST_EMIT
  } state_t;

  // Edge record read from the edge store.
  typedef struct packed {
    logic [NodeW-1:0]   a;
    logic [NodeW-1:0]   b;
    logic [WeightW-1:0] w;
  } edge_t;
endpackage

>>> sv/dpf_edge_store.sv
// Edge list memory: one write port, one registered read port.
// Depends on dpf_pkg.
module dpf_edge_store (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [dpf_pkg::EdgeIdxW-1:0]  wr_addr,
  input  dpf_pkg::edge_t                wr_data,
  input  logic [dpf_pkg::EdgeIdxW-1:0]  rd_addr,
  output dpf_pkg::edge_t                rd_data
);
  dpf_pkg::edge_t mem [dpf_pkg::EdgeCount];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

>>> sv/dijkstra_path_finder.sv
// Shortest-path engine: top level with the query sequencer and node arrays.
// Depends on dpf_pkg and dpf_edge_store.
//
// Append and clear commands complete without leaving idle, so busy never
// rises for them. A query sets busy and runs Dijkstra over 8 nodes with one
// shared compare/add unit: each round scans the nodes for the minimum, then
// walks the edge list through the single read port of the edge memory. One
// more scan finds no candidate and ends the search; then the parent trace
// runs and the route is emitted. Results come out one per cycle with
// result_valid high; the receiver cannot stall them.
// The last node of a route carries last_node.
module dijkstra_path_finder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_we,
  input  logic [dpf_pkg::LimitW-1:0]    cfg_data,
  input  logic [1:0]                    cmd,
  input  logic [dpf_pkg::NodeW-1:0]     edge_from,
  input  logic [dpf_pkg::NodeW-1:0]     edge_to,
  input  logic [dpf_pkg::WeightW-1:0]   edge_weight,
  input  logic [dpf_pkg::NodeW-1:0]     source_node,
  input  logic [dpf_pkg::NodeW-1:0]     dest_node,
  output logic                          result_valid,
  output logic [dpf_pkg::NodeW-1:0]     path_node,
  output logic [dpf_pkg::DistW-1:0]     total_distance,
  output logic                          reachable,
  output logic                          last_node
);
  localparam int NW = dpf_pkg::NodeW;
  localparam int DW = dpf_pkg::DistW;

  dpf_pkg::state_t state, state_next;

  logic [dpf_pkg::LimitW-1:0]   limit;
  logic [dpf_pkg::EdgeCntW-1:0] edge_total;
  logic [DW-1:0]                node_dist [dpf_pkg::NodeCount];
  logic [dpf_pkg::NodeCount-1:0] done;
  logic [dpf_pkg::NodeCount-1:0] has_par;
  logic [NW-1:0]                par [dpf_pkg::NodeCount];
  logic [NW-1:0]                route [dpf_pkg::NodeCount];

  logic [NW-1:0]   dst;
  logic [NW-1:0]   scan;       // node scan index
  logic [DW-1:0]   best;
  logic [NW-1:0]   u;
  logic            found;
  logic [dpf_pkg::EdgeCntW-1:0] eidx; // edge read address, one ahead
  logic            rd_ok;      // edge read data valid this cycle
  logic [NW:0]     cnt;        // route length
  logic [NW-1:0]   cur;
  logic            reach;
  logic [DW-1:0]   dist_out;

  logic            accept;
  logic            do_append;
  dpf_pkg::edge_t  wr_rec, rd_rec;
  logic [DW-1:0]   cand;
  logic [NW-1:0]   nb;
  logic            relax_hit;
  logic [DW-1:0]   limit_ext;

  assign busy      = (state != dpf_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign do_append = accept && (cmd == dpf_pkg::CMD_APPEND) &&
                     (edge_total < dpf_pkg::EdgeCntW'(dpf_pkg::EdgeCount));
  assign wr_rec    = '{a: edge_from, b: edge_to, w: edge_weight};
  assign limit_ext = DW'(limit);

  dpf_edge_store u_store (
    .clk     (clk),
    .wr_en   (do_append),
    .wr_addr (edge_total[dpf_pkg::EdgeIdxW-1:0]),
    .wr_data (wr_rec),
    .rd_addr (eidx[dpf_pkg::EdgeIdxW-1:0]),
    .rd_data (rd_rec)
  );

  // Shared relax unit: pick neighbor, one add, one compare.
  always_comb begin
    nb = rd_rec.b;
    relax_hit = 1'b0;
    if (rd_rec.a == u && !done[rd_rec.b]) begin
      nb = rd_rec.b;
      relax_hit = 1'b1;
    end else if (rd_rec.b == u && !done[rd_rec.a]) begin
      nb = rd_rec.a;
      relax_hit = 1'b1;
    end
    cand = node_dist[u] + DW'(rd_rec.w);
    relax_hit = relax_hit && (cand < node_dist[nb]);
  end

  always_comb begin
    state_next = state;
    case (state)
      dpf_pkg::ST_IDLE:
        if (accept && cmd == dpf_pkg::CMD_QUERY) state_next = dpf_pkg::ST_SELECT;
      dpf_pkg::ST_SELECT:
        if (scan == NW'(dpf_pkg::NodeCount - 1)) begin
          if (found || (!done[scan] && node_dist[scan] < best)) state_next = dpf_pkg::ST_RELAX;
          else state_next = dpf_pkg::ST_TRACE;
        end
      dpf_pkg::ST_RELAX:
        if (eidx == edge_total && (rd_ok || edge_total == '0) && !(rd_ok && eidx != edge_total))
          state_next = dpf_pkg::ST_SELECT;
      dpf_pkg::ST_TRACE:
        if (!reach || !has_par[cur] || cnt == (NW+1)'(dpf_pkg::NodeCount))
          state_next = dpf_pkg::ST_EMIT;
      dpf_pkg::ST_EMIT:
        if (cnt == (NW+1)'(1)) state_next = dpf_pkg::ST_IDLE;
      default: state_next = dpf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= dpf_pkg::ST_IDLE;
    else state <= state_next;
  end

  // Configuration and edge count.
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= dpf_pkg::LimitReset;
      edge_total <= '0;
    end else begin
      if (cfg_we) limit <= cfg_data;
      if (accept && cmd == dpf_pkg::CMD_CLEAR) edge_total <= '0;
      else if (do_append) edge_total <= edge_total + 1'b1;
    end
  end

  // Datapath of the query sequencer.
  always_ff @(posedge clk) begin
    result_valid <= !rst && (state == dpf_pkg::ST_EMIT);
    case (state)
      dpf_pkg::ST_IDLE: begin
        if (accept && cmd == dpf_pkg::CMD_QUERY) begin
          for (int i = 0; i < dpf_pkg::NodeCount; i++) begin
            node_dist[i] <= (NW'(i) == source_node) ? '0 : limit_ext;
          end
          done <= '0;
          has_par <= '0;
          dst <= dest_node;
          scan <= '0;
          best <= limit_ext;
          found <= 1'b0;
        end
      end
      dpf_pkg::ST_SELECT: begin
        // Strict compare keeps the lowest index among equal minima.
        if (!done[scan] && node_dist[scan] < best) begin
          best <= node_dist[scan];
          u <= scan;
          found <= 1'b1;
        end
        scan <= scan + 1'b1;
        if (scan == NW'(dpf_pkg::NodeCount - 1)) begin
          if (found || (!done[scan] && node_dist[scan] < best)) begin
            done[(!done[scan] && node_dist[scan] < best) ? scan : u] <= 1'b1;
            eidx <= '0;
            rd_ok <= 1'b0;
          end else begin
            reach <= node_dist[dst] < limit_ext;
            dist_out <= node_dist[dst];
            cur <= dst;
            route[0] <= dst;
            cnt <= (NW+1)'(1);
          end
        end
      end
      dpf_pkg::ST_RELAX: begin
        // rd_rec holds edge eidx-1 when rd_ok.
        if (rd_ok && relax_hit) begin
          node_dist[nb] <= cand;
          par[nb] <= u;
          has_par[nb] <= 1'b1;
        end
        if (eidx != edge_total) begin
          eidx <= eidx + 1'b1;
          rd_ok <= 1'b1;
        end else begin
          rd_ok <= 1'b0;
        end
        if (state_next == dpf_pkg::ST_SELECT) begin
          scan <= '0;
          best <= limit_ext;
          found <= 1'b0;
        end
      end
      dpf_pkg::ST_TRACE: begin
        if (reach && has_par[cur] && cnt != (NW+1)'(dpf_pkg::NodeCount)) begin
          route[cnt[NW-1:0]] <= par[cur];
          cur <= par[cur];
          cnt <= cnt + 1'b1;
        end
      end
      dpf_pkg::ST_EMIT: begin
        path_node <= route[NW'(cnt - 1'b1)];
        total_distance <= reach ? dist_out : '0;
        reachable <= reach;
        last_node <= (cnt == (NW+1)'(1));
        cnt <= cnt - 1'b1;
      end
      default: ;
    endcase
  end

  // Results appear only while the route is being emitted.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state) == dpf_pkg::ST_EMIT)
    else $error("result outside emit");
  // The edge count never exceeds capacity.
  assert property (@(posedge clk) disable iff (rst)
    edge_total <= dpf_pkg::EdgeCntW'(dpf_pkg::EdgeCount))
    else $error("edge count overflow");
  // The last route node ends the query.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && last_node |-> state == dpf_pkg::ST_IDLE)
    else $error("last node without idle");
endmodule

>>> tb/dijkstra_path_finder_tb.sv
// Testbench for dijkstra_path_finder: directed table plus random graph sessions,
// untyped routes checked against an in-bench shortest-path predictor, typed rows against a hand-written node.
// Depends on dpf_pkg and the dijkstra_path_finder RTL.
`timescale 1ns / 1ps

module dijkstra_path_finder_tb;
  import dpf_pkg::*;

  // One route node as the block reports it.
  typedef struct packed {
    logic [NodeW-1:0] node;
    logic [DistW-1:0] total;
    logic             reach;
    logic             last;
  } route_t;

  // One row of the directed table; typed rows carry a hand-written route node.
  typedef struct {
    cmd_t               c;
    logic [NodeW-1:0]   f;
    logic [NodeW-1:0]   t;
    logic [WeightW-1:0] w;
    logic [NodeW-1:0]   s;
    logic [NodeW-1:0]   d;
    bit                 typed;
    route_t             r;
  } cmd_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic                cfg_we = 1'b0;
  logic [LimitW-1:0]   cfg_data = '0;
  logic [1:0]          cmd = CMD_NONE;
  logic [NodeW-1:0]    edge_from = '0;
  logic [NodeW-1:0]    edge_to = '0;
  logic [WeightW-1:0]  edge_weight = '0;
  logic [NodeW-1:0]    source_node = '0;
  logic [NodeW-1:0]    dest_node = '0;
  logic                result_valid;
  logic [NodeW-1:0]    path_node;
  logic [DistW-1:0]    total_distance;
  logic                reachable;
  logic                last_node;

  // Typed expectation travels alongside the item it belongs to.
  logic                row_typed = 1'b0;
  route_t              row_route = '0;

  // Predictor state: its own copy of the edge list and the limit.
  logic [NodeW-1:0]    graph_a [EdgeCount];
  logic [NodeW-1:0]    graph_b [EdgeCount];
  logic [WeightW-1:0]  graph_w [EdgeCount];
  int unsigned         graph_edges = 0;
  int unsigned         limit_now = LimitReset;

  route_t              route_q[$];
  int                  mismatch_count = 0;
  cmd_row_t            dir_rows[$];
  int                  items_sent = 0;

  dijkstra_path_finder i_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .edge_from      (edge_from),
    .edge_to        (edge_to),
    .edge_weight    (edge_weight),
    .source_node    (source_node),
    .dest_node      (dest_node),
    .result_valid   (result_valid),
    .path_node      (path_node),
    .total_distance (total_distance),
    .reachable      (reachable),
    .last_node      (last_node)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Hard stop for the simulation.
  initial begin
    #(20 * 2000000);
    $display("end of test: mismatches");
    $finish;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH %s: got %0d, want %0d (t=%0t)", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Array Dijkstra over the stored edges; push the route, source first.
  function automatic void compute_route(input logic [NodeW-1:0] src,
                                        input logic [NodeW-1:0] dst);
    int unsigned ndist [NodeCount];
    bit          done [NodeCount];
    int unsigned par [NodeCount];
    bit          has_par [NodeCount];
    int unsigned trail [NodeCount];
    int unsigned best, u, nb, cand, cur, count;
    bit          found, reach;
    route_t      r;
    for (int i = 0; i < NodeCount; i++) begin
      ndist[i] = limit_now;
      done[i] = 1'b0;
      par[i] = 0;
      has_par[i] = 1'b0;
    end
    ndist[src] = 0;
    for (int rnd = 0; rnd < NodeCount; rnd++) begin
      best = limit_now;
      u = 0;
      found = 1'b0;
      // Strict compare keeps the lowest-index minimum.
      for (int j = 0; j < NodeCount; j++) begin
        if (!done[j] && ndist[j] < best) begin
          best = ndist[j];
          u = j;
          found = 1'b1;
        end
      end
      if (!found) break;
      done[u] = 1'b1;
      for (int j = 0; j < graph_edges; j++) begin
        if (graph_a[j] == u && !done[graph_b[j]]) nb = graph_b[j];
        else if (graph_b[j] == u && !done[graph_a[j]]) nb = graph_a[j];
        else continue;
        cand = ndist[u] + graph_w[j];
        if (cand < ndist[nb]) begin
          ndist[nb] = cand;
          par[nb] = u;
          has_par[nb] = 1'b1;
        end
      end
    end
    reach = ndist[dst] < limit_now;
    count = 0;
    cur = dst;
    trail[count++] = cur;
    if (reach) begin
      while (has_par[cur] && count < NodeCount) begin
        cur = par[cur];
        trail[count++] = cur;
      end
    end
    for (int k = 0; k < count; k++) begin
      r.node = NodeW'(trail[count - 1 - k]);
      r.total = reach ? DistW'(ndist[dst]) : '0;
      r.reach = reach;
      r.last = (k + 1 == count);
      route_q.push_back(r);
    end
  endfunction

  // Monitor: sample on the clock edge, before the bench's own updates land.
  always @(posedge clk) begin
    route_t want;
    if (!rst) begin
      if (cfg_we) limit_now = cfg_data;
      if (result_valid) begin
        if (route_q.size() == 0) begin
          report("unexpected route node", path_node, 0);
        end else begin
          want = route_q.pop_front();
          if (path_node !== want.node) report("path_node", path_node, want.node);
          if (total_distance !== want.total) report("total_distance", total_distance, want.total);
          if (reachable !== want.reach) report("reachable", reachable, want.reach);
          if (last_node !== want.last) report("last_node", last_node, want.last);
        end
      end
      if (start && !busy) begin
        case (cmd)
          CMD_APPEND: begin
            // A full list drops the edge.
            if (graph_edges < EdgeCount) begin
              graph_a[graph_edges] = edge_from;
              graph_b[graph_edges] = edge_to;
              graph_w[graph_edges] = edge_weight;
              graph_edges++;
            end
          end
          CMD_CLEAR: graph_edges = 0;
          CMD_QUERY: begin
            if (row_typed) route_q.push_back(row_route);
            else compute_route(source_node, dest_node);
          end
          default: ;
        endcase
      end
    end
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 94) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Present one item, hold it until the transfer, then maybe drop start.
  task automatic drive_item(input cmd_row_t row);
    start <= 1'b1;
    cmd <= row.c;
    edge_from <= row.f;
    edge_to <= row.t;
    edge_weight <= row.w;
    source_node <= row.s;
    dest_node <= row.d;
    row_typed <= row.typed;
    row_route <= row.r;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    begin
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Drain outstanding routes, let the block settle, then write the limit.
  task automatic set_limit(input logic [LimitW-1:0] value);
    start <= 1'b0;
    @(posedge clk);
    while (route_q.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_data <= LimitW'($urandom());
    @(posedge clk);
  endtask

  function automatic cmd_row_t make_row(input cmd_t c, input int f, input int t, input int w,
                                        input int s, input int d);
    cmd_row_t row;
    row.c = c;
    row.f = f;
    row.t = t;
    row.w = w;
    row.s = s;
    row.d = d;
    row.typed = 1'b0;
    row.r = '0;
    return row;
  endfunction

  function automatic cmd_row_t typed_row(input int s, input int d, input int node,
                                         input int total_dist, input bit reach);
    cmd_row_t row;
    row = make_row(CMD_QUERY, 0, 0, 0, s, d);
    row.typed = 1'b1;
    row.r = '{node: NodeW'(node), total: DistW'(total_dist), reach: reach, last: 1'b1};
    return row;
  endfunction

  function automatic cmd_row_t random_row(input cmd_t c);
    cmd_row_t row;
    int w;
    // Mostly short edges so routes stay under the limit; some long ones.
    w = ($urandom_range(9) < 7) ? $urandom_range(300) : $urandom_range(65535);
    row = make_row(c, $urandom_range(7), $urandom_range(7), w,
                   $urandom_range(7), $urandom_range(7));
    return row;
  endfunction

  initial begin
    logic [LimitW-1:0] limits [6];
    int n_edges;
    limits = '{24'd37267, 24'd16777215, 24'd1, 24'd0, 24'd500, 24'd90000};

    // Directed part: empty list, extremes, odd commands, self loop.
    dir_rows.push_back(typed_row(0, 3, 3, 0, 1'b0));      // empty list: unreachable
    dir_rows.push_back(typed_row(2, 2, 2, 0, 1'b1));      // source is destination
    dir_rows.push_back(make_row(CMD_APPEND, 0, 7, 65535, 7, 0));
    dir_rows.push_back(typed_row(0, 7, 7, 0, 1'b0));      // heavier than reset limit
    dir_rows.push_back(make_row(CMD_APPEND, 0, 1, 0, 0, 0));
    dir_rows.push_back(make_row(CMD_APPEND, 1, 2, 5, 5, 2));
    dir_rows.push_back(make_row(CMD_APPEND, 3, 3, 1, 0, 0));  // self loop
    dir_rows.push_back(make_row(CMD_APPEND, 2, 7, 10, 1, 6));
    dir_rows.push_back(make_row(CMD_APPEND, 7, 6, 3, 3, 5));
    dir_rows.push_back(make_row(CMD_QUERY, 0, 0, 0, 0, 6));
    dir_rows.push_back(make_row(CMD_QUERY, 0, 0, 0, 6, 0));
    dir_rows.push_back(typed_row(0, 3, 3, 0, 1'b0));      // only a self loop at node 3
    dir_rows.push_back(make_row(CMD_NONE, 7, 7, 65535, 7, 7));
    dir_rows.push_back(make_row(CMD_APPEND, 0, 2, 1, 0, 0));  // shorter than 0-1-2
    dir_rows.push_back(make_row(CMD_QUERY, 0, 0, 0, 0, 7));
    dir_rows.push_back(make_row(CMD_QUERY, 7, 7, 65535, 7, 1));
    dir_rows.push_back(make_row(CMD_CLEAR, 0, 0, 0, 0, 0));
    dir_rows.push_back(typed_row(0, 6, 6, 0, 1'b0));      // cleared list
    dir_rows.push_back(typed_row(7, 7, 7, 0, 1'b1));

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) drive_item(dir_rows[i]);

    // Random sessions: usually clear, build a graph, run queries; limits change per phase.
    for (int phase = 0; items_sent < 460; phase++) begin
      set_limit(phase < 6 ? limits[phase] : LimitW'($urandom()));
      repeat (4) begin
        if ($urandom_range(3) != 0) drive_item(make_row(CMD_CLEAR, $urandom_range(7),
            $urandom_range(7), $urandom(), $urandom_range(7), $urandom_range(7)));
        // An occasional long build can run the list into its capacity.
        n_edges = ($urandom_range(9) == 0) ? $urandom_range(40, 30) : $urandom_range(12);
        repeat (n_edges) drive_item(random_row(CMD_APPEND));
        repeat ($urandom_range(6, 2)) begin
          if ($urandom_range(9) == 0) drive_item(random_row(CMD_NONE));
          else drive_item(random_row(CMD_QUERY));
        end
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (route_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/dpf_pkg.sv
sv/dpf_edge_store.sv
sv/dijkstra_path_finder.sv
tb/dijkstra_path_finder_tb.sv
